### src/lcrs_pkg.sv
// Shared types and constants for the life chunk row stepper.
// No dependencies; used by every module of the block.
`default_nettype none

package lcrs_pkg;

  // chunk geometry
  localparam int ChunkSide = 64;
  localparam int RowW      = 64;
  localparam int PosW      = 7;
  localparam int IdxW      = 6;
  localparam int CountW    = 13;
  localparam int PopW      = 7;

  // window position of the first row that completes a neighborhood
  localparam logic [PosW-1:0] FirstOutPos = PosW'(2);
  // window position of the south halo row
  localparam logic [PosW-1:0] LastPos     = PosW'(ChunkSide + 1);

  // live columns of a row
  localparam logic [RowW-1:0] RowMask = {RowW{1'b1}} >> (RowW - ChunkSide);

  // one window row with its west and east neighbor cells
  typedef struct packed {
    logic [RowW-1:0] bits;
    logic            west;
    logic            east;
  } row_t;

  // new row on its way from the window stage to the accumulate stage
  typedef struct packed {
    logic            valid;
    logic [RowW-1:0] next_row;
    logic [IdxW-1:0] row_index;
    logic            last_row;
  } stage_t;

endpackage

`default_nettype wire

### src/life_chunk_row_stepper.sv
// Life chunk row stepper, top level. Depends on lcrs_pkg, lcrs_window, lcrs_accum.
// After the row that completes its neighborhood is accepted, its result beat is
// registered in the window stage, then in the accumulate stage output. One row
// beat per cycle while out_stall_i is low, through the two-stage pipeline.
// The north halo row and chunk row 0 give no result beat.
// Reset clears the row window, the window position, the totals and all valids.
`default_nettype none

module life_chunk_row_stepper (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lcrs_pkg::RowW-1:0]    row_bits_i,
  input  logic                         west_bit_i,
  input  logic                         east_bit_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lcrs_pkg::RowW-1:0]    next_row_o,
  output logic [lcrs_pkg::IdxW-1:0]    row_index_o,
  output logic                         last_row_o,
  output logic [lcrs_pkg::RowW-1:0]    nonempty_rows_o,
  output logic [lcrs_pkg::RowW-1:0]    west_edge_rows_o,
  output logic [lcrs_pkg::RowW-1:0]    east_edge_rows_o,
  output logic [lcrs_pkg::CountW-1:0]  live_count_o
);
  import lcrs_pkg::*;

  stage_t stage;
  logic   out_advance;
  logic   stage_advance;
  logic   accept;

  // the window stage moves when its register is empty or drains
  assign stage_advance = !stage.valid || out_advance;
  assign in_stall_o    = !stage_advance;
  assign accept        = in_valid_i && stage_advance;

  lcrs_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .advance_i (stage_advance),
    .row_bits_i(row_bits_i),
    .west_bit_i(west_bit_i),
    .east_bit_i(east_bit_i),
    .stage_o   (stage)
  );

  lcrs_accum u_accum (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .stage_i         (stage),
    .out_stall_i     (out_stall_i),
    .advance_o       (out_advance),
    .out_valid_o     (out_valid_o),
    .next_row_o      (next_row_o),
    .row_index_o     (row_index_o),
    .last_row_o      (last_row_o),
    .nonempty_rows_o (nonempty_rows_o),
    .west_edge_rows_o(west_edge_rows_o),
    .east_edge_rows_o(east_edge_rows_o),
    .live_count_o    (live_count_o)
  );

endmodule

`default_nettype wire

### src/lcrs_rule.sv
// B3/S23 next-generation logic for one row, carry-save neighbor count.
// Depends on lcrs_pkg.
`default_nettype none

module lcrs_rule (
  input  lcrs_pkg::row_t              older_i,
  input  lcrs_pkg::row_t              middle_i,
  input  lcrs_pkg::row_t              incoming_i,
  output logic [lcrs_pkg::RowW-1:0]   next_row_o
);
  import lcrs_pkg::*;

  logic [RowW-1:0] n0, n1, n2, n3, n4, n5, n6, n7;
  logic [RowW-1:0] p0, s0, c0, p1, s1, c1, s2, c2, p3, ones, c3;
  logic [RowW-1:0] px, twos, fours, low, two, three;

  // neighbor planes, shifted with the halo cells filled in
  always_comb begin
    n0 = ({older_i.bits[RowW-2:0], 1'b0} | RowW'(older_i.west)) & RowMask;
    n1 = older_i.bits;
    n2 = ((older_i.bits >> 1) | (RowW'(older_i.east) << (ChunkSide - 1))) & RowMask;
    n3 = ({middle_i.bits[RowW-2:0], 1'b0} | RowW'(middle_i.west)) & RowMask;
    n4 = ((middle_i.bits >> 1) | (RowW'(middle_i.east) << (ChunkSide - 1))) & RowMask;
    n5 = ({incoming_i.bits[RowW-2:0], 1'b0} | RowW'(incoming_i.west)) & RowMask;
    n6 = incoming_i.bits;
    n7 = ((incoming_i.bits >> 1) | (RowW'(incoming_i.east) << (ChunkSide - 1)))
         & RowMask;
  end

  // carry-save tree down to ones, twos and fours planes
  always_comb begin
    p0   = n0 ^ n1;
    s0   = p0 ^ n2;
    c0   = (n0 & n1) | (p0 & n2);
    p1   = n3 ^ n4;
    s1   = p1 ^ n5;
    c1   = (n3 & n4) | (p1 & n5);
    s2   = n6 ^ n7;
    c2   = n6 & n7;
    p3   = s0 ^ s1;
    ones = p3 ^ s2;
    c3   = (s0 & s1) | (p3 & s2);
    px    = c0 ^ c1;
    twos  = px ^ c2 ^ c3;
    fours = (c0 & c1) | (c2 & c3) | (px & (c2 ^ c3));
  end

  // birth on three, survival on two or three
  always_comb begin
    low        = twos & ~fours;
    two        = low & ~ones;
    three      = low & ones;
    next_row_o = (three | (middle_i.bits & two)) & RowMask;
  end

endmodule

`default_nettype wire

### src/lcrs_window.sv
// Window stage: keeps the two previous rows and the window position,
// registers each new row with its index. Depends on lcrs_pkg, lcrs_rule.
`default_nettype none

module lcrs_window (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       advance_i,
  input  logic [lcrs_pkg::RowW-1:0]  row_bits_i,
  input  logic                       west_bit_i,
  input  logic                       east_bit_i,
  output lcrs_pkg::stage_t           stage_o
);
  import lcrs_pkg::*;

  row_t            older_q, older_d;
  row_t            middle_q, middle_d;
  row_t            incoming;
  logic [PosW-1:0] pos_q, pos_d;
  logic [RowW-1:0] next_row;
  logic            has_result;
  logic            is_last;
  stage_t          stage_q, stage_d;

  assign incoming.bits = row_bits_i & RowMask;
  assign incoming.west = west_bit_i;
  assign incoming.east = east_bit_i;

  lcrs_rule u_rule (
    .older_i   (older_q),
    .middle_i  (middle_q),
    .incoming_i(incoming),
    .next_row_o(next_row)
  );

  assign has_result = (pos_q >= FirstOutPos);
  assign is_last    = (pos_q >= LastPos);

  // window shift, restart after the south halo row
  always_comb begin
    older_d  = older_q;
    middle_d = middle_q;
    pos_d    = pos_q;
    if (accept_i) begin
      if (has_result && is_last) begin
        older_d  = '0;
        middle_d = '0;
        pos_d    = '0;
      end else begin
        older_d  = middle_q;
        middle_d = incoming;
        pos_d    = pos_q + PosW'(1);
      end
    end
  end

  // stage register payload
  always_comb begin
    stage_d           = stage_q;
    if (advance_i) begin
      stage_d.valid     = accept_i && has_result;
      stage_d.next_row  = next_row;
      stage_d.row_index = IdxW'(pos_q - FirstOutPos);
      stage_d.last_row  = is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q  <= '0;
      middle_q <= '0;
      pos_q    <= '0;
      stage_q  <= '0;
    end else begin
      older_q  <= older_d;
      middle_q <= middle_d;
      pos_q    <= pos_d;
      stage_q  <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

`default_nettype wire

### src/lcrs_accum.sv
// Accumulate stage: row masks and live count, output register.
// Depends on lcrs_pkg.
`default_nettype none

module lcrs_accum (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lcrs_pkg::stage_t             stage_i,
  input  logic                         out_stall_i,
  output logic                         advance_o,
  output logic                         out_valid_o,
  output logic [lcrs_pkg::RowW-1:0]    next_row_o,
  output logic [lcrs_pkg::IdxW-1:0]    row_index_o,
  output logic                         last_row_o,
  output logic [lcrs_pkg::RowW-1:0]    nonempty_rows_o,
  output logic [lcrs_pkg::RowW-1:0]    west_edge_rows_o,
  output logic [lcrs_pkg::RowW-1:0]    east_edge_rows_o,
  output logic [lcrs_pkg::CountW-1:0]  live_count_o
);
  import lcrs_pkg::*;

  logic [1:0]        lvl1 [32];
  logic [2:0]        lvl2 [16];
  logic [3:0]        lvl3 [8];
  logic [4:0]        lvl4 [4];
  logic [5:0]        lvl5 [2];
  logic [PopW-1:0]   pop;
  logic [RowW-1:0]   row_bit;
  logic [RowW-1:0]   rows_acc_q, rows_acc_d, rows_new;
  logic [RowW-1:0]   west_acc_q, west_acc_d, west_new;
  logic [RowW-1:0]   east_acc_q, east_acc_d, east_new;
  logic [CountW-1:0] count_acc_q, count_acc_d, count_new;
  logic              out_valid_q;
  logic [RowW-1:0]   next_row_q;
  logic [IdxW-1:0]   row_index_q;
  logic              last_row_q;
  logic [RowW-1:0]   rows_q, west_q, east_q;
  logic [CountW-1:0] count_q;
  logic              take;

  assign advance_o = !out_valid_q || !out_stall_i;
  assign take      = advance_o && stage_i.valid;

  // population count tree of the new row
  always_comb begin
    for (int i = 0; i < 32; i++) begin
      lvl1[i] = {1'b0, stage_i.next_row[2*i]} + {1'b0, stage_i.next_row[2*i+1]};
    end
    for (int i = 0; i < 16; i++) begin
      lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      lvl3[i] = {1'b0, lvl2[2*i]} + {1'b0, lvl2[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      lvl4[i] = {1'b0, lvl3[2*i]} + {1'b0, lvl3[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      lvl5[i] = {1'b0, lvl4[2*i]} + {1'b0, lvl4[2*i+1]};
    end
    pop = {1'b0, lvl5[0]} + {1'b0, lvl5[1]};
  end

  // running totals including this row
  always_comb begin
    row_bit   = RowW'(1) << stage_i.row_index;
    rows_new  = rows_acc_q | ((stage_i.next_row != '0) ? row_bit : '0);
    west_new  = west_acc_q | (stage_i.next_row[0] ? row_bit : '0);
    east_new  = east_acc_q | (stage_i.next_row[ChunkSide-1] ? row_bit : '0);
    count_new = count_acc_q + CountW'(pop);
  end

  // totals restart after the last row of a chunk
  always_comb begin
    rows_acc_d  = rows_acc_q;
    west_acc_d  = west_acc_q;
    east_acc_d  = east_acc_q;
    count_acc_d = count_acc_q;
    if (take) begin
      if (stage_i.last_row) begin
        rows_acc_d  = '0;
        west_acc_d  = '0;
        east_acc_d  = '0;
        count_acc_d = '0;
      end else begin
        rows_acc_d  = rows_new;
        west_acc_d  = west_new;
        east_acc_d  = east_new;
        count_acc_d = count_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_acc_q  <= '0;
      west_acc_q  <= '0;
      east_acc_q  <= '0;
      count_acc_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rows_acc_q  <= rows_acc_d;
      west_acc_q  <= west_acc_d;
      east_acc_q  <= east_acc_d;
      count_acc_q <= count_acc_d;
      if (advance_o) begin
        out_valid_q <= stage_i.valid;
      end
    end
  end

  // output beat payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      next_row_q  <= stage_i.next_row;
      row_index_q <= stage_i.row_index;
      last_row_q  <= stage_i.last_row;
      rows_q      <= rows_new;
      west_q      <= west_new;
      east_q      <= east_new;
      count_q     <= count_new;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign next_row_o       = next_row_q;
  assign row_index_o      = row_index_q;
  assign last_row_o       = last_row_q;
  assign nonempty_rows_o  = rows_q;
  assign west_edge_rows_o = west_q;
  assign east_edge_rows_o = east_q;
  assign live_count_o     = count_q;

endmodule

`default_nettype wire

### src/lcrs_checker.sv
// Port-level checks for the life chunk row stepper, bound to the top level.
// Depends on lcrs_pkg and life_chunk_row_stepper.
`default_nettype none

module lcrs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [lcrs_pkg::RowW-1:0]    next_row_o,
  input logic [lcrs_pkg::IdxW-1:0]    row_index_o,
  input logic                         last_row_o,
  input logic [lcrs_pkg::RowW-1:0]    nonempty_rows_o,
  input logic [lcrs_pkg::RowW-1:0]    west_edge_rows_o
);
  import lcrs_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(next_row_o))
    else $error("result beat changed while stalled");

  // last flag exactly on the final chunk row
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_row_o == (row_index_o == IdxW'(ChunkSide - 1))))
    else $error("last_row does not match row_index");

  // first row of a chunk starts with fresh masks
  a_first_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (row_index_o == '0) |-> (nonempty_rows_o[RowW-1:1] == '0))
    else $error("row mask not cleared at chunk start");

  // mask bits of the current row agree with the row itself
  a_row_masks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (nonempty_rows_o[row_index_o] == (next_row_o != '0)) &&
                    (west_edge_rows_o[row_index_o] == next_row_o[0]))
    else $error("row masks disagree with next_row");

endmodule

bind life_chunk_row_stepper lcrs_checker u_lcrs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .next_row_o      (next_row_o),
  .row_index_o     (row_index_o),
  .last_row_o      (last_row_o),
  .nonempty_rows_o (nonempty_rows_o),
  .west_edge_rows_o(west_edge_rows_o)
);

`default_nettype wire
